// ===== rtl/core/alle_pkg.sv =====
// Shared types and codes for the array linked list engine.
// No dependencies; imported by the datapath, controller and top modules.
package alle_pkg;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam int KEY_W = 32;

    // controller -> datapath
    typedef struct packed {
        logic       load_req;   // capture request, start walk at head
        logic       walk_step;  // pre <= cur, cur <= link[cur]
        logic       unlink;     // link[pre] <= link[cur]
        logic       app_node;   // write key/link of fresh slot, bump count
        logic       app_link;   // hook fresh slot after tail
        logic       out_load;   // move result into output register
        logic [1:0] res_code;
    } alle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_del;
        logic full;
        logic cur_zero;
        logic key_match;
        logic out_free;
    } alle_stat_t;

endpackage

// ===== rtl/core/alle_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/alle_datapath.sv =====
// Datapath: head/tail/count registers, walk pointers, key and link RAMs, result register.
// Depends on alle_pkg and alle_ram.
module alle_datapath #(
    parameter int NODES = 1024,
    localparam int IDX_W = $clog2(NODES),
    localparam int CNT_W = $clog2(NODES + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  alle_pkg::alle_cmd_t               cmd,
    output alle_pkg::alle_stat_t              stat,
    input  logic                              s_req_type,
    input  logic signed [alle_pkg::KEY_W-1:0] s_key_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [IDX_W-1:0]                  m_slot
);
    import alle_pkg::*;

    logic                    req_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        alloc_reg, alloc_next;
    logic [IDX_W-1:0]        cur_reg, pre_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_status_reg;
    logic [IDX_W-1:0]        m_slot_reg;

    logic [IDX_W-1:0]        fresh;
    logic                    link_we;
    logic [IDX_W-1:0]        link_waddr, link_wdata, link_rdata;
    logic [KEY_W-1:0]        key_rdata;

    assign fresh = IDX_W'(alloc_reg + CNT_W'(1));

    // head link lives in head_reg; RAM entry 0 is never used
    always_comb begin
        link_we    = 1'b0;
        link_waddr = fresh;
        link_wdata = '0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        alloc_next = alloc_reg;
        if (cmd.app_node) begin
            link_we    = 1'b1;
            alloc_next = alloc_reg + CNT_W'(1);
        end
        if (cmd.app_link) begin
            tail_next = slot_reg;
            if (tail_reg == '0) begin
                head_next = slot_reg;
            end else begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = slot_reg;
            end
        end
        if (cmd.unlink) begin
            if (link_rdata == '0) begin
                tail_next = pre_reg;
            end
            if (pre_reg == '0) begin
                head_next = link_rdata;
            end else begin
                link_we    = 1'b1;
                link_waddr = pre_reg;
                link_wdata = link_rdata;
            end
        end
    end

    alle_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_reg),
        .rdata (link_rdata)
    );

    alle_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.app_node),
        .waddr (fresh),
        .wdata (key_reg),
        .raddr (cur_reg),
        .rdata (key_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            alloc_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            alloc_reg   <= alloc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_req_type;
            key_reg <= s_key_value;
            cur_reg <= head_reg;
            pre_reg <= '0;
        end
        if (cmd.walk_step) begin
            pre_reg <= cur_reg;
            cur_reg <= link_rdata;
        end
        if (cmd.app_node) begin
            slot_reg <= fresh;
        end
        if (cmd.unlink) begin
            slot_reg <= cur_reg;
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.res_code;
            m_slot_reg   <= (cmd.res_code == ST_DONE) ? slot_reg : '0;
        end
    end

    assign stat.req_del   = (req_reg == REQ_DELETE);
    assign stat.full      = (alloc_reg >= CNT_W'(NODES - 1));
    assign stat.cur_zero  = (cur_reg == '0);
    assign stat.key_match = (key_rdata == key_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

// ===== rtl/core/alle_ctrl.sv =====
// Controller state machine: sequences append, delete walk and result handoff.
// Depends on alle_pkg.
module alle_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  alle_pkg::alle_stat_t stat,
    output alle_pkg::alle_cmd_t  cmd
);
    import alle_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISP     = 3'd1;
    localparam logic [2:0] S_APP_NODE = 3'd2;
    localparam logic [2:0] S_APP_LINK = 3'd3;
    localparam logic [2:0] S_RD       = 3'd4;
    localparam logic [2:0] S_CMP      = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] code_reg, code_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd.res_code = code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP: begin
                if (stat.req_del) begin
                    state_next = S_RD;
                end else if (stat.full) begin
                    code_next  = ST_FULL;
                    state_next = S_FIN;
                end else begin
                    state_next = S_APP_NODE;
                end
            end
            S_APP_NODE: begin
                cmd.app_node = 1'b1;
                state_next   = S_APP_LINK;
            end
            S_APP_LINK: begin
                cmd.app_link = 1'b1;
                code_next    = ST_DONE;
                state_next   = S_FIN;
            end
            // RAM read of cur is in flight; data valid in S_CMP
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                priority if (stat.cur_zero) begin
                    code_next  = ST_NOT_FOUND;
                    state_next = S_FIN;
                end else if (stat.key_match) begin
                    cmd.unlink = 1'b1;
                    code_next  = ST_DONE;
                    state_next = S_FIN;
                end else begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_DONE;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ===== rtl/core/array_linked_list_engine.sv =====
// Array linked list engine: one request at a time, one result per request.
// Append: tail kept in a register, no walk; states dispatch, node write, link write, finish;
//   an append on a full list goes from dispatch straight to finish.
// Delete: each node visited takes a read and a compare state on the key/link RAM
//   read port; the walk stops at a match or at the end of the list, which holds
//   at most NODES-1 nodes. A waiting result adds its stall.
// Next request is taken once the result has moved into the output register.
// Synchronous active-low reset empties the list at once; no RAM clearing pass.
module array_linked_list_engine #(
    parameter int NODES = 1024,
    localparam int IDX_W = $clog2(NODES)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic signed [alle_pkg::KEY_W-1:0] s_key_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [IDX_W-1:0]                  m_slot
);
    import alle_pkg::*;

    alle_cmd_t  cmd;
    alle_stat_t stat;

    alle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    alle_datapath #(.NODES(NODES)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_req_type  (s_req_type),
        .s_key_value (s_key_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_slot      (m_slot)
    );

    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in progress");

    // the head sentinel is never reported as a slot
    a_done_slot_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_DONE) |-> (m_slot != '0))
        else $error("done result reports head slot");

    a_fail_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DONE) |-> (m_slot == '0))
        else $error("failed result carries a nonzero slot");

endmodule
